// ===== rtl/grnts_pkg.sv =====
// Shared constants, field layout and types for the grid ring nearest tile search unit.
// Used by the top level and by its port checker.
package grnts_pkg;

	localparam int MAX_GRID_SIDE = 256;
	localparam int NODE_ID_BITS  = 16;
	localparam int MAX_DEPTH     = 255;

	localparam int TABLE_AW  = 16;
	localparam int ENTRY_W   = NODE_ID_BITS + 1;
	localparam int GIDX_W    = $clog2(MAX_GRID_SIDE);
	localparam int GDIM_W    = $clog2(MAX_GRID_SIDE + 1);
	localparam int RAD_W     = $clog2(MAX_DEPTH + 1);
	localparam int PROD_W    = GIDX_W + GDIM_W;

	localparam int GRID_REG_W = 9;
	localparam int POS_W      = 24;
	localparam int TSIZE_W    = 16;
	localparam int DEPTH_W    = 8;
	localparam int ID_W       = 16;
	localparam int DIFF_W     = POS_W + 1;
	localparam int COORD_W    = ((DIFF_W > RAD_W) ? DIFF_W : RAD_W) + 2;
	localparam int DIV_CNT_W  = $clog2(DIFF_W);
	localparam int DIV_LAST   = DIFF_W - 1;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 24;

	localparam int SLOT_LSB  = 0;
	localparam int HAS_BIT   = SLOT_LSB + TABLE_AW;
	localparam int ID_LSB    = HAS_BIT + 1;
	localparam int PX_LSB    = ID_LSB + ID_W;
	localparam int PZ_LSB    = PX_LSB + POS_W;
	localparam int DEPTH_LSB = PZ_LSB + POS_W;
	localparam int IN_DW     = ((DEPTH_LSB + DEPTH_W + 7) / 8) * 8;

	localparam int NODE_LSB = 0;
	localparam int TILE_LSB = NODE_LSB + ID_W;
	localparam int OUT_DW   = TILE_LSB + TABLE_AW;

	typedef enum logic [CFG_AW-1:0] {
		CFG_GRID_WIDTH,
		CFG_GRID_HEIGHT,
		CFG_ORIGIN_X,
		CFG_ORIGIN_Z,
		CFG_TILE_SIZE
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE,
		OP_SEARCH
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_WALK,
		ST_END,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_TOP,
		PH_BOTTOM,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

endpackage

// ===== rtl/grid_ring_nearest_tile_search_unit.sv =====
// Top level of the grid ring nearest tile search unit: tile table memory, divider and ring walker.
// Depends on grnts_pkg.
// A write request is written to the table as it is accepted. A search request runs the divider
// (one quotient bit per cycle), then per ring side a setup state and one in-grid cell read per
// cycle from the single table read port; a hit or the last ring ends in done, and an empty
// grid or depth 0 goes straight to done. One request at a time; a finished result waits in the
// output register while the next is taken. Reset: asynchronous, active low; after it all 65536
// table entries are cleared, one per cycle, with input ready low; configuration writes are taken throughout.
module grid_ring_nearest_tile_search_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: tile_slot, has_center, center_id, pos_x, pos_z, search_depth, zero pad
	input  logic [grnts_pkg::IN_DW-1:0]   s_axis_tdata,
	// tuser: opcode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: found_node, found_tile
	output logic [grnts_pkg::OUT_DW-1:0]  m_axis_tdata,
	// tuser: found
	output logic                          m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [grnts_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [grnts_pkg::CFG_DW-1:0]  cfg_data
);

	localparam int TABLE_DEPTH = 2 ** grnts_pkg::TABLE_AW;

	grnts_pkg::state_t state_q, state_d;

	logic [grnts_pkg::GRID_REG_W-1:0] grid_w_q, grid_h_q;
	logic signed [grnts_pkg::POS_W-1:0] org_x_q, org_z_q;
	logic [grnts_pkg::TSIZE_W-1:0] tsize_q;

	logic [grnts_pkg::GDIM_W-1:0] w_eff, h_eff;
	logic [grnts_pkg::TSIZE_W-1:0] unit;
	logic grid_empty;

	grnts_pkg::opcode_t in_op;
	logic [grnts_pkg::TABLE_AW-1:0] in_slot;
	logic in_has;
	logic [grnts_pkg::ID_W-1:0] in_id;
	logic signed [grnts_pkg::POS_W-1:0] in_px, in_pz;
	logic [grnts_pkg::DEPTH_W-1:0] in_depth;
	logic [grnts_pkg::RAD_W-1:0] depth_eff;
	logic in_acc;

	logic signed [grnts_pkg::DIFF_W-1:0] diff_x, diff_z;
	logic [grnts_pkg::DIFF_W-1:0] mag_x, mag_z;

	logic neg_x_q, neg_z_q;
	logic [grnts_pkg::DIFF_W-1:0] dvd_x_q, dvd_z_q, dvd_x_nx, dvd_z_nx;
	logic [grnts_pkg::TSIZE_W-1:0] rem_x_q, rem_z_q, rem_x_nx, rem_z_nx;
	logic [grnts_pkg::TSIZE_W:0] rem_x_sh, rem_z_sh;
	logic ge_x, ge_z;
	logic [grnts_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic div_last;
	logic signed [grnts_pkg::COORD_W-1:0] qx_s, qz_s;
	logic signed [grnts_pkg::COORD_W-1:0] cx_q, cz_q;

	logic [grnts_pkg::RAD_W-1:0] r_q, depth_q;
	grnts_pkg::phase_t phase_q;
	logic [grnts_pkg::GIDX_W-1:0] cur_q, hi_q, fix_q;

	logic signed [grnts_pkg::COORD_W-1:0] r_c, x0, x1, z0, z1, w_s, h_s;
	logic signed [grnts_pkg::COORD_W-1:0] st_fix, st_lo, st_hi;
	logic st_skip;
	logic last_phase;
	grnts_pkg::state_t adv_state;

	logic [grnts_pkg::GIDX_W-1:0] cell_x, cell_z;
	logic [grnts_pkg::PROD_W-1:0] prod;
	logic [grnts_pkg::PROD_W:0] idx_sum;
	logic [grnts_pkg::TABLE_AW-1:0] rd_addr;
	logic walk_last;

	logic [grnts_pkg::ENTRY_W-1:0] tbl_mem [TABLE_DEPTH];
	logic [grnts_pkg::ENTRY_W-1:0] rd_data_s1;
	logic [grnts_pkg::TABLE_AW-1:0] rd_addr_s1;
	logic rd_vld_s1;
	logic rd_issue;
	logic hit;

	logic mem_we;
	logic [grnts_pkg::TABLE_AW-1:0] mem_waddr;
	logic [grnts_pkg::ENTRY_W-1:0] mem_wdata;
	logic [grnts_pkg::TABLE_AW-1:0] clr_q;
	logic clr_last;

	logic res_found_q;
	logic [grnts_pkg::ID_W-1:0] res_node_q;
	logic [grnts_pkg::TABLE_AW-1:0] res_tile_q;
	logic load_out;
	logic out_vld_q, out_found_q;
	logic [grnts_pkg::ID_W-1:0] out_node_q;
	logic [grnts_pkg::TABLE_AW-1:0] out_tile_q;

	assign w_eff = (32'(grid_w_q) > grnts_pkg::MAX_GRID_SIDE) ?
		grnts_pkg::GDIM_W'(grnts_pkg::MAX_GRID_SIDE) : grnts_pkg::GDIM_W'(grid_w_q);
	assign h_eff = (32'(grid_h_q) > grnts_pkg::MAX_GRID_SIDE) ?
		grnts_pkg::GDIM_W'(grnts_pkg::MAX_GRID_SIDE) : grnts_pkg::GDIM_W'(grid_h_q);
	assign unit = (tsize_q == '0) ? grnts_pkg::TSIZE_W'(1) : tsize_q;
	assign grid_empty = (w_eff == '0) || (h_eff == '0);

	assign in_op    = grnts_pkg::opcode_t'(s_axis_tuser);
	assign in_slot  = s_axis_tdata[grnts_pkg::SLOT_LSB +: grnts_pkg::TABLE_AW];
	assign in_has   = s_axis_tdata[grnts_pkg::HAS_BIT];
	assign in_id    = s_axis_tdata[grnts_pkg::ID_LSB +: grnts_pkg::ID_W];
	assign in_px    = $signed(s_axis_tdata[grnts_pkg::PX_LSB +: grnts_pkg::POS_W]);
	assign in_pz    = $signed(s_axis_tdata[grnts_pkg::PZ_LSB +: grnts_pkg::POS_W]);
	assign in_depth = s_axis_tdata[grnts_pkg::DEPTH_LSB +: grnts_pkg::DEPTH_W];
	assign depth_eff = (32'(in_depth) > grnts_pkg::MAX_DEPTH) ?
		grnts_pkg::RAD_W'(grnts_pkg::MAX_DEPTH) : grnts_pkg::RAD_W'(in_depth);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign diff_x = grnts_pkg::DIFF_W'(in_px) - grnts_pkg::DIFF_W'(org_x_q);
	assign diff_z = grnts_pkg::DIFF_W'(in_pz) - grnts_pkg::DIFF_W'(org_z_q);
	assign mag_x  = (diff_x < 0) ? grnts_pkg::DIFF_W'(-diff_x) : grnts_pkg::DIFF_W'(diff_x);
	assign mag_z  = (diff_z < 0) ? grnts_pkg::DIFF_W'(-diff_z) : grnts_pkg::DIFF_W'(diff_z);

	// restoring division, one quotient bit per cycle on each axis
	assign rem_x_sh = {rem_x_q, dvd_x_q[grnts_pkg::DIFF_W-1]};
	assign rem_z_sh = {rem_z_q, dvd_z_q[grnts_pkg::DIFF_W-1]};
	assign ge_x = rem_x_sh >= {1'b0, unit};
	assign ge_z = rem_z_sh >= {1'b0, unit};
	assign rem_x_nx = ge_x ? grnts_pkg::TSIZE_W'(rem_x_sh - {1'b0, unit}) :
		grnts_pkg::TSIZE_W'(rem_x_sh);
	assign rem_z_nx = ge_z ? grnts_pkg::TSIZE_W'(rem_z_sh - {1'b0, unit}) :
		grnts_pkg::TSIZE_W'(rem_z_sh);
	assign dvd_x_nx = {dvd_x_q[grnts_pkg::DIFF_W-2:0], ge_x};
	assign dvd_z_nx = {dvd_z_q[grnts_pkg::DIFF_W-2:0], ge_z};
	assign div_last = (div_cnt_q == grnts_pkg::DIV_CNT_W'(grnts_pkg::DIV_LAST));
	assign qx_s = $signed(grnts_pkg::COORD_W'(dvd_x_nx));
	assign qz_s = $signed(grnts_pkg::COORD_W'(dvd_z_nx));

	// ring side bounds, clamped to the grid
	assign r_c = $signed(grnts_pkg::COORD_W'(r_q));
	assign x0  = cx_q - r_c;
	assign x1  = cx_q + r_c;
	assign z0  = cz_q - r_c;
	assign z1  = cz_q + r_c;
	assign w_s = $signed(grnts_pkg::COORD_W'(w_eff));
	assign h_s = $signed(grnts_pkg::COORD_W'(h_eff));

	always_comb begin
		st_fix  = '0;
		st_lo   = '0;
		st_hi   = '0;
		st_skip = 1'b1;
		unique case (phase_q)
			grnts_pkg::PH_TOP, grnts_pkg::PH_BOTTOM: begin
				st_fix  = (phase_q == grnts_pkg::PH_TOP) ? z0 : z1;
				st_lo   = (x0 < 0) ? '0 : x0;
				st_hi   = (x1 >= w_s) ? w_s - grnts_pkg::COORD_W'(1) : x1;
				st_skip = (st_fix < 0) || (st_fix >= h_s) || (st_lo > st_hi);
			end
			grnts_pkg::PH_LEFT, grnts_pkg::PH_RIGHT: begin
				st_fix  = (phase_q == grnts_pkg::PH_LEFT) ? x0 : x1;
				st_lo   = (z0 + grnts_pkg::COORD_W'(1) < 0) ? '0 :
					z0 + grnts_pkg::COORD_W'(1);
				st_hi   = (z1 - grnts_pkg::COORD_W'(1) >= h_s) ?
					h_s - grnts_pkg::COORD_W'(1) : z1 - grnts_pkg::COORD_W'(1);
				st_skip = (st_fix < 0) || (st_fix >= w_s) || (st_lo > st_hi);
			end
			default: begin
				st_skip = 1'b1;
			end
		endcase
	end

	assign last_phase = (phase_q == grnts_pkg::PH_RIGHT);
	assign adv_state  = (last_phase && (r_q == depth_q)) ? grnts_pkg::ST_END : grnts_pkg::ST_SETUP;

	assign cell_x  = (phase_q == grnts_pkg::PH_TOP || phase_q == grnts_pkg::PH_BOTTOM) ?
		cur_q : fix_q;
	assign cell_z  = (phase_q == grnts_pkg::PH_TOP || phase_q == grnts_pkg::PH_BOTTOM) ?
		fix_q : cur_q;
	assign prod    = grnts_pkg::PROD_W'(cell_z) * grnts_pkg::PROD_W'(w_eff);
	assign idx_sum = (grnts_pkg::PROD_W + 1)'(prod) + (grnts_pkg::PROD_W + 1)'(cell_x);
	assign rd_addr = grnts_pkg::TABLE_AW'(idx_sum);
	assign walk_last = (cur_q == hi_q);

	assign hit = rd_vld_s1 && rd_data_s1[grnts_pkg::ENTRY_W-1];
	assign clr_last = &clr_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grnts_pkg::ST_CLEAR: begin
				if (clr_last)
					state_d = grnts_pkg::ST_IDLE;
			end
			grnts_pkg::ST_IDLE: begin
				if (in_acc && in_op == grnts_pkg::OP_SEARCH) begin
					if (grid_empty || depth_eff == '0)
						state_d = grnts_pkg::ST_DONE;
					else
						state_d = grnts_pkg::ST_DIV;
				end
			end
			grnts_pkg::ST_DIV: begin
				if (div_last)
					state_d = grnts_pkg::ST_SETUP;
			end
			grnts_pkg::ST_SETUP: begin
				if (hit)
					state_d = grnts_pkg::ST_DONE;
				else if (!st_skip)
					state_d = grnts_pkg::ST_WALK;
				else
					state_d = adv_state;
			end
			grnts_pkg::ST_WALK: begin
				if (hit)
					state_d = grnts_pkg::ST_DONE;
				else if (walk_last)
					state_d = adv_state;
			end
			grnts_pkg::ST_END: begin
				state_d = grnts_pkg::ST_DONE;
			end
			grnts_pkg::ST_DONE: begin
				if (!out_vld_q || m_axis_tready)
					state_d = grnts_pkg::ST_IDLE;
			end
			default: begin
				state_d = grnts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_issue      = 1'b0;
		load_out      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = in_slot;
		mem_wdata     = {in_has, grnts_pkg::NODE_ID_BITS'(in_id)};
		unique case (state_q)
			grnts_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			grnts_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_we        = in_acc && (in_op == grnts_pkg::OP_WRITE);
			end
			grnts_pkg::ST_WALK: begin
				rd_issue = !hit;
			end
			grnts_pkg::ST_DONE: begin
				load_out = !out_vld_q || m_axis_tready;
			end
			grnts_pkg::ST_DIV, grnts_pkg::ST_SETUP, grnts_pkg::ST_END: begin
				rd_issue = 1'b0;
			end
			default: begin
				rd_issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grnts_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == grnts_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= '0;
			grid_h_q <= '0;
			org_x_q  <= '0;
			org_z_q  <= '0;
			tsize_q  <= grnts_pkg::TSIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (grnts_pkg::cfg_reg_t'(cfg_addr))
				grnts_pkg::CFG_GRID_WIDTH:  grid_w_q <= cfg_data[grnts_pkg::GRID_REG_W-1:0];
				grnts_pkg::CFG_GRID_HEIGHT: grid_h_q <= cfg_data[grnts_pkg::GRID_REG_W-1:0];
				grnts_pkg::CFG_ORIGIN_X:    org_x_q  <= $signed(cfg_data[grnts_pkg::POS_W-1:0]);
				grnts_pkg::CFG_ORIGIN_Z:    org_z_q  <= $signed(cfg_data[grnts_pkg::POS_W-1:0]);
				grnts_pkg::CFG_TILE_SIZE:   tsize_q  <= cfg_data[grnts_pkg::TSIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grnts_pkg::ST_IDLE && in_acc && in_op == grnts_pkg::OP_SEARCH) begin
			neg_x_q   <= diff_x < 0;
			neg_z_q   <= diff_z < 0;
			dvd_x_q   <= mag_x;
			dvd_z_q   <= mag_z;
			rem_x_q   <= '0;
			rem_z_q   <= '0;
			div_cnt_q <= '0;
			depth_q   <= depth_eff;
			r_q       <= grnts_pkg::RAD_W'(1);
			phase_q   <= grnts_pkg::PH_TOP;
		end
		if (state_q == grnts_pkg::ST_DIV) begin
			dvd_x_q   <= dvd_x_nx;
			dvd_z_q   <= dvd_z_nx;
			rem_x_q   <= rem_x_nx;
			rem_z_q   <= rem_z_nx;
			div_cnt_q <= div_cnt_q + 1'b1;
			if (div_last) begin
				cx_q <= neg_x_q ? -qx_s : qx_s;
				cz_q <= neg_z_q ? -qz_s : qz_s;
			end
		end
		if (state_q == grnts_pkg::ST_SETUP && !hit && !st_skip) begin
			cur_q <= grnts_pkg::GIDX_W'(st_lo);
			hi_q  <= grnts_pkg::GIDX_W'(st_hi);
			fix_q <= grnts_pkg::GIDX_W'(st_fix);
		end
		if (state_q == grnts_pkg::ST_WALK && !hit && !walk_last)
			cur_q <= cur_q + 1'b1;
		if (!hit && ((state_q == grnts_pkg::ST_SETUP && st_skip) ||
				(state_q == grnts_pkg::ST_WALK && walk_last))) begin
			if (last_phase) begin
				phase_q <= grnts_pkg::PH_TOP;
				r_q     <= r_q + 1'b1;
			end else begin
				phase_q <= grnts_pkg::phase_t'(phase_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tbl_mem[mem_waddr] <= mem_wdata;
		if (rd_issue) begin
			rd_data_s1 <= tbl_mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_s1 <= 1'b0;
		else
			rd_vld_s1 <= rd_issue;
	end

	always_ff @(posedge clk) begin
		if (state_q == grnts_pkg::ST_IDLE && in_acc && in_op == grnts_pkg::OP_SEARCH) begin
			res_found_q <= 1'b0;
			res_node_q  <= '0;
			res_tile_q  <= '0;
		end else if (hit) begin
			res_found_q <= 1'b1;
			res_node_q  <= grnts_pkg::ID_W'(rd_data_s1[grnts_pkg::NODE_ID_BITS-1:0]);
			res_tile_q  <= rd_addr_s1;
		end
		if (load_out) begin
			out_found_q <= res_found_q;
			out_node_q  <= res_node_q;
			out_tile_q  <= res_tile_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load_out)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {out_tile_q, out_node_q};

endmodule

// ===== rtl/grnts_checker.sv =====
// Port-level checker for the grid ring nearest tile search unit, bound to the top level.
// Depends on grnts_pkg.
module grnts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [grnts_pkg::OUT_DW-1:0]  m_axis_tdata,
	input logic                          m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("not-found result carries nonzero data");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("search request did not hold off the input");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
		else $error("table write request stalled the input");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a search in progress");

endmodule

bind grid_ring_nearest_tile_search_unit grnts_checker u_grnts_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_ring_nearest_tile_search_unit: tile writes and ring searches
// are checked against an in-bench nearest tile predictor. Depends on grnts_pkg and the top level.
module tb_top;

	typedef struct packed {
		logic        found;
		logic [15:0] node;
		logic [15:0] tile;
	} tile_hit_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [grnts_pkg::IN_DW-1:0]     s_axis_tdata  = '0;
	logic                            s_axis_tuser  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [grnts_pkg::OUT_DW-1:0]    m_axis_tdata;
	logic                            m_axis_tuser;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [grnts_pkg::CFG_AW-1:0]    cfg_addr      = '0;
	logic [grnts_pkg::CFG_DW-1:0]    cfg_data      = '0;

	bit          tile_has [65536];
	bit [15:0]   tile_node [65536];
	logic [8:0]  grid_w   = 9'd0;
	logic [8:0]  grid_h   = 9'd0;
	logic signed [23:0] org_x = '0;
	logic signed [23:0] org_z = '0;
	logic [15:0] tile_len = 16'd1;

	tile_hit_t pending_hits [$];
	int        error_count  = 0;
	int        random_sent  = 0;
	int        sink_hold    = 0;
	bit        steady_flow  = 1'b0;
	longint    cycle_count  = 0;
	longint    cycle_budget = 200000;

	grid_ring_nearest_tile_search_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint eff_side(input logic [8:0] side);
		return (side > grnts_pkg::MAX_GRID_SIDE) ? grnts_pkg::MAX_GRID_SIDE : longint'(side);
	endfunction

	function automatic bit probe_cell(input longint x, input longint z, input longint w,
			output tile_hit_t hit);
		logic [15:0] idx;
		idx = 16'(x + z * w);
		hit = '0;
		if (!tile_has[idx])
			return 1'b0;
		hit.found = 1'b1;
		hit.node  = tile_node[idx];
		hit.tile  = idx;
		return 1'b1;
	endfunction

	function automatic tile_hit_t nearest_tile(input logic signed [23:0] px,
			input logic signed [23:0] pz, input logic [7:0] depth);
		longint    w, h, unit, cx, cz, r, x, z, lo, hi;
		int        i;
		tile_hit_t res;
		res  = '0;
		w    = eff_side(grid_w);
		h    = eff_side(grid_h);
		unit = (tile_len == 0) ? 1 : longint'(tile_len);
		if (w == 0 || h == 0)
			return res;
		cx = (longint'(px) - longint'(org_x)) / unit;
		cz = (longint'(pz) - longint'(org_z)) / unit;
		for (r = 1; r <= longint'(depth); r++) begin
			for (i = 0; i < 2; i++) begin
				z = (i == 0) ? cz - r : cz + r;
				if (z >= 0 && z < h) begin
					lo = (cx - r < 0) ? 0 : cx - r;
					hi = (cx + r >= w) ? w - 1 : cx + r;
					for (x = lo; x <= hi; x++)
						if (probe_cell(x, z, w, res))
							return res;
				end
			end
			for (i = 0; i < 2; i++) begin
				x = (i == 0) ? cx - r : cx + r;
				if (x >= 0 && x < w) begin
					lo = (cz - r + 1 < 0) ? 0 : cz - r + 1;
					hi = (cz + r - 1 >= h) ? h - 1 : cz + r - 1;
					for (z = lo; z <= hi; z++)
						if (probe_cell(x, z, w, res))
							return res;
				end
			end
		end
		return '0;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 4 * cycle_budget) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Check each accepted result against the oldest expected hit.
	always @(posedge clk) begin
		tile_hit_t want;
		tile_hit_t got;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got.found = m_axis_tuser;
			got.node  = m_axis_tdata[grnts_pkg::NODE_LSB +: grnts_pkg::ID_W];
			got.tile  = m_axis_tdata[grnts_pkg::TILE_LSB +: grnts_pkg::TABLE_AW];
			if (pending_hits.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result found=%0b node=%h tile=%h", $time,
					got.found, got.node, got.tile);
			end else begin
				want = pending_hits.pop_front();
				if (got !== want) begin
					error_count++;
					if (got.found !== want.found)
						$display("%0t: found expected %0b actual %0b", $time,
							want.found, got.found);
					if (got.node !== want.node)
						$display("%0t: found_node expected %h actual %h", $time,
							want.node, got.node);
					if (got.tile !== want.tile)
						$display("%0t: found_tile expected %h actual %h", $time,
							want.tile, got.tile);
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		forever begin
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = steady_flow ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1 && sink_hold == 0);
		end
	end

	task automatic write_reg(input grnts_pkg::cfg_reg_t idx, input logic [23:0] value);
		cycle_budget += 8;
		cfg_addr  <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			grnts_pkg::CFG_GRID_WIDTH:  grid_w   = value[8:0];
			grnts_pkg::CFG_GRID_HEIGHT: grid_h   = value[8:0];
			grnts_pkg::CFG_ORIGIN_X:    org_x    = value;
			grnts_pkg::CFG_ORIGIN_Z:    org_z    = value;
			grnts_pkg::CFG_TILE_SIZE:   tile_len = value[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_grid(input logic [8:0] w, input logic [8:0] h,
			input logic [23:0] ox, input logic [23:0] oz, input logic [15:0] ts);
		write_reg(grnts_pkg::CFG_GRID_WIDTH, 24'(w));
		write_reg(grnts_pkg::CFG_GRID_HEIGHT, 24'(h));
		write_reg(grnts_pkg::CFG_ORIGIN_X, ox);
		write_reg(grnts_pkg::CFG_ORIGIN_Z, oz);
		write_reg(grnts_pkg::CFG_TILE_SIZE, 24'(ts));
	endtask

	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_request(input grnts_pkg::opcode_t op, input logic [15:0] slot,
			input logic has, input logic [15:0] id, input logic [23:0] px,
			input logic [23:0] pz, input logic [7:0] depth);
		int                          gap;
		longint                      cells;
		logic [grnts_pkg::IN_DW-1:0] word;
		gap  = steady_flow ? 0 : $urandom_range(0, 8);
		word = '0;
		word[grnts_pkg::SLOT_LSB +: grnts_pkg::TABLE_AW] = slot;
		word[grnts_pkg::HAS_BIT]                         = has;
		word[grnts_pkg::ID_LSB +: grnts_pkg::ID_W]       = id;
		word[grnts_pkg::PX_LSB +: grnts_pkg::POS_W]      = px;
		word[grnts_pkg::PZ_LSB +: grnts_pkg::POS_W]      = pz;
		word[grnts_pkg::DEPTH_LSB +: grnts_pkg::DEPTH_W] = depth;
		cells = (2 * longint'(depth) + 1) * (2 * longint'(depth) + 1);
		if (cells > eff_side(grid_w) * eff_side(grid_h))
			cells = eff_side(grid_w) * eff_side(grid_h);
		cycle_budget += (op == grnts_pkg::OP_SEARCH) ? 60 + 6 * longint'(depth) + cells : 24;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= word;
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (op == grnts_pkg::OP_WRITE) begin
			tile_has[slot]  = has;
			tile_node[slot] = id;
		end else begin
			pending_hits.insert(pending_hits.size(), nearest_tile(px, pz, depth));
		end
	endtask

	task automatic put_tile(input logic [15:0] slot, input logic has, input logic [15:0] id);
		send_request(grnts_pkg::OP_WRITE, slot, has, id, 24'($urandom), 24'($urandom),
			8'($urandom));
	endtask

	task automatic find_tile(input logic [23:0] px, input logic [23:0] pz,
			input logic [7:0] depth);
		send_request(grnts_pkg::OP_SEARCH, 16'($urandom), 1'($urandom), 16'($urandom), px, pz,
			depth);
	endtask

	task automatic test_empty_grid();
		find_tile(24'd0, 24'd0, 8'd4);
		wait_for_idle();
		apply_grid(9'd4, 9'd0, 24'd0, 24'd0, 16'd1);
		find_tile(24'd1, 24'd1, 8'd3);
		wait_for_idle();
		write_reg(grnts_pkg::CFG_GRID_WIDTH, 24'd0);
		write_reg(grnts_pkg::CFG_GRID_HEIGHT, 24'd4);
		find_tile(24'd1, 24'd1, 8'd3);
	endtask

	task automatic test_single_ring();
		wait_for_idle();
		apply_grid(9'd8, 9'd8, 24'd0, 24'd0, 16'd1);
		put_tile(16'd29, 1'b1, 16'hFFFF);
		put_tile(16'd0, 1'b1, 16'h0000);
		find_tile(24'd3, 24'd3, 8'd0);
		find_tile(24'd3, 24'd3, 8'd1);
		find_tile(24'd3, 24'd3, 8'd2);
		find_tile(24'd5, 24'd3, 8'd1);
		find_tile(24'd1, 24'd1, 8'd1);
		put_tile(16'd29, 1'b0, 16'h1234);
		find_tile(24'd3, 24'd3, 8'd2);
	endtask

	task automatic test_ring_order();
		wait_for_idle();
		apply_grid(9'd6, 9'd5, 24'd100, -24'sd100, 16'd4);
		put_tile(16'd15, 1'b1, 16'h0F0F);
		put_tile(16'd9, 1'b1, 16'h0909);
		put_tile(16'd19, 1'b1, 16'h1313);
		find_tile(24'd109, -24'sd89, 8'd1);
		put_tile(16'd9, 1'b0, 16'h0000);
		find_tile(24'd109, -24'sd89, 8'd1);
	endtask

	task automatic test_coordinate_extremes();
		wait_for_idle();
		apply_grid(9'd511, 9'd300, 24'h800000, 24'h7FFFFF, 16'd0);
		find_tile(24'h7FFFFF, 24'h800000, 8'd255);
		find_tile(24'h800000, 24'h7FFFFF, 8'd3);
		wait_for_idle();
		apply_grid(9'd4, 9'd4, 24'd0, 24'd0, 16'hFFFF);
		put_tile(16'hFFFF, 1'b1, 16'hFFFF);
		put_tile(16'd1, 1'b1, 16'h00A5);
		find_tile(-24'sd65534, 24'd131075, 8'd2);
		wait_for_idle();
		write_reg(grnts_pkg::CFG_TILE_SIZE, 24'd3);
		find_tile(-24'sd2, 24'd0, 8'd1);
	endtask

	task automatic test_deep_full_grid();
		wait_for_idle();
		apply_grid(9'd256, 9'd256, 24'd0, 24'd0, 16'd1);
		find_tile(24'd255, 24'd255, 8'd255);
		find_tile(24'd255, 24'd255, 8'd254);
	endtask

	task automatic test_output_stall();
		wait_for_idle();
		apply_grid(9'd5, 9'd5, 24'd0, 24'd0, 16'd2);
		put_tile(16'd12, 1'b1, 16'h0C0C);
		wait_for_idle();
		cycle_budget += 600;
		sink_hold   = 500;
		steady_flow = 1'b1;
		for (int i = 0; i < 8; i++)
			find_tile(24'($urandom_range(0, 9)), 24'($urandom_range(0, 9)), 8'($urandom_range(0, 3)));
		steady_flow = 1'b0;
	endtask

	task automatic test_random_phases();
		logic [8:0]  w, h;
		logic [23:0] ox, oz;
		logic [15:0] ts;
		logic [7:0]  depth;
		longint      we, he, unit, cell_x, cell_z;
		int          count;
		while (random_sent < 1900) begin
			wait_for_idle();
			case ($urandom_range(0, 9))
				0:       w = 9'd0;
				1:       w = 9'($urandom_range(257, 511));
				2:       w = 9'd256;
				default: w = 9'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 9))
				0:       h = 9'd0;
				1:       h = 9'($urandom_range(257, 511));
				2:       h = 9'($urandom_range(17, 256));
				default: h = 9'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 5))
				0:       ts = 16'd0;
				1:       ts = 16'($urandom);
				2:       ts = 16'hFFFF;
				default: ts = 16'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 5))
				0:       begin ox = 24'($urandom); oz = 24'($urandom); end
				1:       begin ox = 24'h800000; oz = 24'h7FFFFF; end
				2:       begin ox = 24'h7FFFFF; oz = 24'h800000; end
				default: begin
					ox = 24'(int'($urandom_range(0, 200)) - 100);
					oz = 24'(int'($urandom_range(0, 200)) - 100);
				end
			endcase
			apply_grid(w, h, ox, oz, ts);
			we          = eff_side(grid_w);
			he          = eff_side(grid_h);
			unit        = (tile_len == 0) ? 1 : longint'(tile_len);
			steady_flow = ($urandom_range(0, 3) == 0);
			count       = $urandom_range(15, 60);
			for (int n = 0; n < count; n++) begin
				case ($urandom_range(0, 4))
					0:       depth = 8'($urandom);
					1:       depth = 8'($urandom_range(0, 24));
					default: depth = 8'($urandom_range(0, 6));
				endcase
				if (we * he > 4096 && depth > 12)
					depth = 8'($urandom_range(0, 12));
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6: begin
						cell_x = (we > 0) ? $urandom_range(0, we - 1) : 0;
						cell_z = (he > 0) ? $urandom_range(0, he - 1) : 0;
						put_tile(16'(cell_x + cell_z * we), ($urandom_range(0, 3) != 0),
							16'($urandom));
					end
					7, 8:
						put_tile(16'($urandom), 1'($urandom), 16'($urandom));
					9, 10:
						find_tile(24'($urandom), 24'($urandom), depth);
					default: begin
						cell_x = longint'($urandom_range(0, we + 5)) - 3;
						cell_z = longint'($urandom_range(0, he + 5)) - 3;
						find_tile(24'(longint'(org_x) + cell_x * unit + $urandom_range(0, unit - 1)),
							24'(longint'(org_z) + cell_z * unit + $urandom_range(0, unit - 1)),
							depth);
					end
				endcase
				random_sent++;
			end
			steady_flow = 1'b0;
		end
	endtask

	initial begin : run_sequence
		int drain_cycles;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_grid();
		test_single_ring();
		test_ring_order();
		test_coordinate_extremes();
		test_deep_full_grid();
		test_output_stall();
		test_random_phases();
		s_axis_tvalid <= 1'b0;
		drain_cycles = 0;
		while (pending_hits.size() != 0 && drain_cycles < 300000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (100) @(posedge clk);
		if (pending_hits.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected results never arrived", $time, pending_hits.size());
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/grnts_pkg.sv
rtl/grid_ring_nearest_tile_search_unit.sv
rtl/grnts_checker.sv
tb/sv/tb_top.sv
